// ===== hdl/kfq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfq_pkg: shared types for the keyed FIFO queue
// Item formats, operation and status codes, and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package kfq_pkg;

  localparam int KEY_W   = 16;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 5;

  // operation codes
  typedef enum logic [1:0] {
    FN_APPEND  = 2'd0,
    FN_RM_HEAD = 2'd1,
    FN_LOOKUP  = 2'd2,
    FN_RM_KEY  = 2'd3
  } func_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // read address relative to the walk pointer
  typedef enum logic [1:0] {
    RD_CUR  = 2'd0,
    RD_NEXT = 2'd1,
    RD_SKIP = 2'd2
  } rd_sel_t;

  typedef struct packed {
    func_t              func;
    logic [KEY_W-1:0]   item_key;
    logic [DATA_W-1:0]  item_data;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [KEY_W-1:0]    match_key;
    logic [DATA_W-1:0]   match_data;
    logic [KEY_W-1:0]    head_key;
    logic [DATA_W-1:0]   head_data;
    logic [COUNT_W-1:0]  entry_count;
    logic                is_empty;
  } out_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [DATA_W-1:0]  data;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic     ld_item;
    logic     append;
    rd_sel_t  rd_sel;
    logic     p_inc;
    logic     cap_match;
    logic     shift_wr;
    logic     fin;
    logic     dec;
    status_t  status;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic hit;
    logic last;
    logic last2;
  } dp_stat_t;

endpackage

// ===== hdl/keyed_fifo_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_fifo_queue: ordered store of key and data entries with keyed search
//
// Drive in_item and raise start; the item is taken at an edge where busy is
// low. Operations: append at the tail, remove the head, look up the first
// entry with a matching key, remove the first matching entry (the gap is
// closed and order kept). Each item gives exactly one result, shown on
// out_item for a single cycle with out_valid high; the receiver cannot stall.
// An append or an operation on an empty store goes straight to the result;
// a search walks from the head to the first hit (or to the end on a miss),
// a keyed removal then shifts the later entries down a slot, and a head
// removal shifts all the rest down. The memory has one read port, so the
// search and the shift each visit one entry per cycle. A new item is taken
// in the cycle the result is shown. Reset empties the store at once; no
// clearing pass is needed since slots at or past the count are never used.
// ----------------------------------------------------------------------------
module keyed_fifo_queue #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  kfq_pkg::in_item_t  in_item,
  output logic               out_valid,
  output kfq_pkg::out_item_t out_item
);

  kfq_pkg::dp_cmd_t  cmd;
  kfq_pkg::dp_stat_t stat;

  kfq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_item.func),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  kfq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_item  (out_item),
    .out_valid (out_valid)
  );

endmodule

// ===== hdl/kfq_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfq_datapath: entry store, walk pointer and result register
// Holds the entries in a single-port-write, registered-read memory, keeps
// the count and a copy of the head entry, and builds the result item.
// ----------------------------------------------------------------------------
module kfq_datapath #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  kfq_pkg::in_item_t  in_item,
  input  kfq_pkg::dp_cmd_t   cmd,
  output kfq_pkg::dp_stat_t  stat,
  output kfq_pkg::out_item_t out_item,
  output logic               out_valid
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  kfq_pkg::entry_t    mem_r [DEPTH];
  kfq_pkg::entry_t    rd_q_r;
  kfq_pkg::entry_t    item_r;
  kfq_pkg::entry_t    head_r;
  kfq_pkg::entry_t    match_r;
  kfq_pkg::out_item_t out_r;
  logic               out_valid_r;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      p_r;

  logic [CW:0]        p_ext;
  logic [CW:0]        cnt_ext;
  logic [CW:0]        rd_sum;
  logic [IW-1:0]      rd_addr;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  kfq_pkg::entry_t    wr_entry;
  logic [CW-1:0]      cnt_new;

  assign p_ext   = {1'b0, p_r};
  assign cnt_ext = {1'b0, count_r};

  // pick the read address off the walk pointer
  always_comb begin
    case (cmd.rd_sel)
      kfq_pkg::RD_CUR:  rd_sum = p_ext;
      kfq_pkg::RD_NEXT: rd_sum = p_ext + (CW + 1)'(1);
      kfq_pkg::RD_SKIP: rd_sum = p_ext + (CW + 1)'(2);
      default:          rd_sum = p_ext;
    endcase
  end
  assign rd_addr = rd_sum[IW-1:0];

  // write at the tail on append, one slot down on a shift step
  always_comb begin
    wr_en    = cmd.append | cmd.shift_wr;
    wr_addr  = cmd.append ? count_r[IW-1:0] : p_r[IW-1:0];
    wr_entry = cmd.append ? item_r : rd_q_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_entry;
    end
    rd_q_r <= mem_r[rd_addr];
  end

  // flags for the controller
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.hit   = (rd_q_r.key == item_r.key);
  assign stat.last  = ((p_ext + (CW + 1)'(1)) == cnt_ext);
  assign stat.last2 = ((p_ext + (CW + 1)'(2)) == cnt_ext);

  assign cnt_new = cmd.dec ? (count_r - CW'(1)) : count_r;

  // payload registers: latched item, head copy, match, pointer, result
  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      item_r.key  <= in_item.item_key;
      item_r.data <= in_item.item_data;
      match_r     <= '0;
      p_r         <= '0;
    end else begin
      if (cmd.cap_match) begin
        match_r <= rd_q_r;
      end
      if (cmd.p_inc) begin
        p_r <= p_r + CW'(1);
      end
    end
    if (cmd.append && (count_r == '0)) begin
      head_r <= item_r;
    end else if (cmd.shift_wr && (p_r == '0)) begin
      head_r <= rd_q_r;
    end
    if (cmd.fin) begin
      out_r.status      <= cmd.status;
      out_r.match_key   <= match_r.key;
      out_r.match_data  <= match_r.data;
      out_r.head_key    <= (cnt_new == '0) ? '0 : head_r.key;
      out_r.head_data   <= (cnt_new == '0) ? '0 : head_r.data;
      out_r.entry_count <= kfq_pkg::COUNT_W'(cnt_new);
      out_r.is_empty    <= (cnt_new == '0);
    end
  end

  // control registers: count and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.fin;
      if (cmd.append) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.fin) begin
        count_r <= cnt_new;
      end
    end
  end

  assign out_item  = out_r;
  assign out_valid = out_valid_r;

endmodule

// ===== hdl/kfq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfq_ctrl: operation sequencer for the keyed FIFO queue
// Dispatches each operation, walks the store for a key search, steps the
// gap-closing shift one entry a cycle and closes with the result.
// ----------------------------------------------------------------------------
module kfq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  kfq_pkg::func_t     in_func,
  input  kfq_pkg::dp_stat_t  stat,
  output kfq_pkg::dp_cmd_t   cmd,
  output logic               busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SHIFT,
    S_FIN
  } state_t;

  state_t             state_r, state_nxt;
  kfq_pkg::func_t     func_r, func_nxt;
  kfq_pkg::status_t   st_r, st_nxt;
  logic               dec_r, dec_nxt;
  logic               busy_r;

  // next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    st_nxt        = st_r;
    dec_nxt       = dec_r;
    cmd.ld_item   = 1'b0;
    cmd.append    = 1'b0;
    cmd.rd_sel    = kfq_pkg::RD_NEXT;
    cmd.p_inc     = 1'b0;
    cmd.cap_match = 1'b0;
    cmd.shift_wr  = 1'b0;
    cmd.fin       = 1'b0;
    cmd.dec       = 1'b0;
    cmd.status    = st_r;
    case (state_r)
      S_IDLE: begin
        if (start && !busy_r) begin
          cmd.ld_item = 1'b1;
          func_nxt    = in_func;
          st_nxt      = kfq_pkg::ST_OK;
          dec_nxt     = 1'b0;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        case (func_r)
          kfq_pkg::FN_APPEND: begin
            if (stat.full) begin
              st_nxt = kfq_pkg::ST_FULL;
            end else begin
              cmd.append = 1'b1;
            end
            state_nxt = S_FIN;
          end
          kfq_pkg::FN_RM_HEAD: begin
            if (stat.empty) begin
              st_nxt    = kfq_pkg::ST_EMPTY;
              state_nxt = S_FIN;
            end else begin
              // fetch slot 1 to slide into the head
              dec_nxt   = 1'b1;
              state_nxt = stat.last ? S_FIN : S_SHIFT;
            end
          end
          default: begin
            if (stat.empty) begin
              st_nxt    = kfq_pkg::ST_NOT_FOUND;
              state_nxt = S_FIN;
            end else begin
              cmd.rd_sel = kfq_pkg::RD_CUR;
              state_nxt  = S_SCAN;
            end
          end
        endcase
      end
      S_SCAN: begin
        // check the entry at the pointer, fetch the one after it
        if (stat.hit) begin
          cmd.cap_match = 1'b1;
          if (func_r == kfq_pkg::FN_RM_KEY) begin
            dec_nxt   = 1'b1;
            state_nxt = stat.last ? S_FIN : S_SHIFT;
          end else begin
            state_nxt = S_FIN;
          end
        end else if (stat.last) begin
          st_nxt    = kfq_pkg::ST_NOT_FOUND;
          state_nxt = S_FIN;
        end else begin
          cmd.p_inc = 1'b1;
        end
      end
      S_SHIFT: begin
        // move one entry down, prefetch the next
        cmd.shift_wr = 1'b1;
        if (stat.last2) begin
          state_nxt = S_FIN;
        end else begin
          cmd.rd_sel = kfq_pkg::RD_SKIP;
          cmd.p_inc  = 1'b1;
        end
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        cmd.dec   = dec_r;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
      func_r  <= kfq_pkg::FN_APPEND;
      st_r    <= kfq_pkg::ST_OK;
      dec_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
      func_r  <= func_nxt;
      st_r    <= st_nxt;
      dec_r   <= dec_nxt;
    end
  end

  assign busy = busy_r;

endmodule
